@@ rtl/linear_scan_priority_queue_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the linear scan priority queue
// Implication checks, same cycle and next cycle, compiled out by NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef LINEAR_SCAN_PRIORITY_QUEUE_MACROS_SVH
`define LINEAR_SCAN_PRIORITY_QUEUE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define LSPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`define LSPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define LSPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)

`define LSPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ rtl/lspq_pkg.sv @@
// ----------------------------------------------------------------------------
// Linear scan priority queue package
// Payload types, operation and status codes, controller to datapath structs.
// ----------------------------------------------------------------------------
package lspq_pkg;

	localparam int DEPTH_DEFAULT = 128;

	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	typedef struct packed {
		logic               op;
		logic signed [31:0] item_value;
		logic        [7:0]  item_priority;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] out_value;
		logic        [7:0]  out_priority;
		logic        [1:0]  status;
		logic        [7:0]  occupancy;
	} out_item_t;

	typedef struct packed {
		logic load_req;
		logic dispatch;
		logic scan_start;
		logic scan_step;
		logic shift_start;
		logic shift_step;
		logic dec_count;
		logic load_result;
	} cmd_t;

	typedef struct packed {
		logic op;
		logic empty;
		logic pass_done;
		logic out_free;
	} sts_t;

endpackage

@@ rtl/lspq_stream_if.sv @@
// ----------------------------------------------------------------------------
// Valid/ready stream channel
// One request moves at each clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface lspq_stream_if #(
	parameter type payload_t = logic
) ();

	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

@@ rtl/lspq_ctrl.sv @@
// ----------------------------------------------------------------------------
// Linear scan priority queue controller
// Sequences dispatch, maximum scan, gap closing shift and result hand-off.
// ----------------------------------------------------------------------------
module lspq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  lspq_pkg::sts_t sts,
	output lspq_pkg::cmd_t cmd
);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_DISPATCH = 3'd1;
	localparam logic [2:0] ST_SCAN     = 3'd2;
	localparam logic [2:0] ST_SHIFT    = 3'd3;
	localparam logic [2:0] ST_RESULT   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d      = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				cmd.dispatch = 1'b1;
				if (sts.op == lspq_pkg::OP_DEQ && !sts.empty) begin
					cmd.scan_start = 1'b1;
					state_d        = ST_SCAN;
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.pass_done) begin
					cmd.shift_start = 1'b1;
					state_d         = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				cmd.shift_step = 1'b1;
				if (sts.pass_done) begin
					cmd.dec_count = 1'b1;
					state_d       = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (sts.out_free) begin
					cmd.load_result = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/lspq_datapath.sv @@
// ----------------------------------------------------------------------------
// Linear scan priority queue datapath
// Entry memory, count, scan pointer, best entry tracking and result register.
// ----------------------------------------------------------------------------
`include "linear_scan_priority_queue_macros.svh"

module lspq_datapath #(
	parameter int DEPTH = lspq_pkg::DEPTH_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lspq_pkg::cmd_t      cmd,
	output lspq_pkg::sts_t      sts,
	input  lspq_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output lspq_pkg::out_item_t out_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = 40;

	logic [EW-1:0] entry_mem [DEPTH];

	lspq_pkg::in_item_t  req_q;
	lspq_pkg::out_item_t out_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       rp_q;
	logic [1:0]          stat_q;
	logic                rd_vld_s1;
	logic [AW-1:0]       rd_idx_s1;
	logic [EW-1:0]       rd_data_s1;
	logic [AW-1:0]       best_idx_q;
	logic [EW-1:0]       best_q;
	logic                out_valid_q;

	logic          full;
	logic          rd_en;
	logic          enq_commit;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [EW-1:0] wr_data;
	logic          take_best;

	assign full       = (count_q == CW'(DEPTH));
	assign rd_en      = (cmd.scan_step || cmd.shift_step) && (rp_q < count_q);
	assign enq_commit = cmd.dispatch && (req_q.op == lspq_pkg::OP_ENQ) && !full;
	assign wr_en      = enq_commit || (cmd.shift_step && rd_vld_s1);
	assign wr_addr    = enq_commit ? count_q[AW-1:0] : (rd_idx_s1 - AW'(1));
	assign wr_data    = enq_commit ? {req_q.item_priority, req_q.item_value} : rd_data_s1;
	assign take_best  = cmd.scan_step && rd_vld_s1 &&
		((rd_idx_s1 == '0) || (rd_data_s1[EW-1:32] > best_q[EW-1:32]));

	assign sts.op        = req_q.op;
	assign sts.empty     = (count_q == '0);
	assign sts.pass_done = (rp_q == count_q) && !rd_vld_s1;
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= entry_mem[rp_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rp_q        <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (enq_commit) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.dec_count) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.scan_start) begin
				rp_q <= '0;
			end else if (cmd.shift_start) begin
				rp_q <= CW'(best_idx_q) + CW'(1);
			end else if (rd_en) begin
				rp_q <= rp_q + CW'(1);
			end
			rd_vld_s1 <= rd_en;
			if (cmd.load_result) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= in_data;
		end
		if (rd_en) begin
			rd_idx_s1 <= rp_q[AW-1:0];
		end
		if (take_best) begin
			best_q     <= rd_data_s1;
			best_idx_q <= rd_idx_s1;
		end
		if (cmd.dispatch) begin
			if (req_q.op == lspq_pkg::OP_ENQ) begin
				stat_q <= full ? lspq_pkg::STATUS_FULL : lspq_pkg::STATUS_OK;
			end else begin
				stat_q <= (count_q == '0) ? lspq_pkg::STATUS_EMPTY : lspq_pkg::STATUS_OK;
			end
		end
		if (cmd.load_result) begin
			if (req_q.op == lspq_pkg::OP_DEQ && stat_q == lspq_pkg::STATUS_OK) begin
				out_q.out_value    <= signed'(best_q[31:0]);
				out_q.out_priority <= best_q[EW-1:32];
			end else begin
				out_q.out_value    <= '0;
				out_q.out_priority <= '0;
			end
			out_q.status    <= stat_q;
			out_q.occupancy <= 8'(count_q);
		end
	end

	`LSPQ_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(DEPTH), "count above depth")
	`LSPQ_ASSERT_IMP(a_dec_nonempty, clk, arst_n, cmd.dec_count, count_q != '0, "remove from empty")
	`LSPQ_ASSERT_IMP(a_shift_target, clk, arst_n, cmd.shift_step && rd_vld_s1, rd_idx_s1 != '0, "shift writes below head")
	`LSPQ_ASSERT_NEXT(a_full_hold, clk, arst_n, cmd.dispatch && req_q.op == lspq_pkg::OP_ENQ && full, $stable(count_q), "refused enqueue changed count")

endmodule

@@ rtl/linear_scan_priority_queue.sv @@
// ----------------------------------------------------------------------------
// Linear scan priority queue
// Unsorted arrival-order store with maximum scan and gap closing on dequeue.
//
//   channel   dir   payload      meaning
//   in_ch     in    in_item_t    enqueue or dequeue request
//   out_ch    out   out_item_t   one result per request
//
// Enqueue, refused enqueue and empty dequeue go from accept through dispatch to
// result load. A dequeue adds one pass over the entries for the maximum and one
// pass moving later entries down, both through the single read port of the
// entry memory. The next request is taken in the cycle after the result load.
// Reset clears the count, scan pointer, read valid and output valid, not the entry memory; no clearing pass.
// A stalled result holds in the output register; the next request is taken
// once that result is loaded.
// ----------------------------------------------------------------------------
module linear_scan_priority_queue #(
	parameter int DEPTH = lspq_pkg::DEPTH_DEFAULT
) (
	input logic          clk,
	input logic          arst_n,
	lspq_stream_if.sink   in_ch,
	lspq_stream_if.source out_ch
);

	lspq_pkg::cmd_t      cmd;
	lspq_pkg::sts_t      sts;
	lspq_pkg::in_item_t  in_data;
	lspq_pkg::out_item_t out_data;
	logic                in_ready;
	logic                out_valid;

	assign in_data      = in_ch.data;
	assign in_ch.ready  = in_ready;
	assign out_ch.valid = out_valid;
	assign out_ch.data  = out_data;

	lspq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lspq_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ch.ready),
		.out_data  (out_data)
	);

endmodule
